@@ hw/rtl/rarc_pkg.sv @@
// Package for the rational add/reduce/compare core.
// Holds result field widths and the command/status structs between control and datapath.
// No dependencies.
package rarc_pkg;

    localparam int SUM_NUM_W = 33;
    localparam int SUM_DEN_W = 31;

    typedef logic signed [SUM_NUM_W-1:0] t_sum_num;
    typedef logic [SUM_DEN_W-1:0]        t_sum_den;

    typedef struct packed {
        logic load;
        logic mul;
        logic add;
        logic gcd_step;
        logic div_init;
        logic div_step;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic gcd_done;
    } t_sts;

endpackage

@@ hw/rtl/rational_add_reduce_compare_core.sv @@
// Rational add with gcd reduction and compare: load, cross multiply, add, binary gcd steps,
// then the two dividers, then the output load; one binary gcd shift/subtract per cycle.
// A new word is taken only in idle, after the previous result has gone to the output register;
// the two dividers run one quotient bit a cycle.
// Next word is taken while a finished result still waits on the output register.
// Reset (i_rst_n, synchronous, active low) idles the controller and clears output valid.
// Depends on rarc_pkg, rarc_ctrl, rarc_dp.
module rational_add_reduce_compare_core #(
    parameter int OPERAND_WIDTH = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic signed [OPERAND_WIDTH-1:0] i_a_num,
    input  logic        [OPERAND_WIDTH-2:0] i_a_den,
    input  logic signed [OPERAND_WIDTH-1:0] i_b_num,
    input  logic        [OPERAND_WIDTH-2:0] i_b_den,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output rarc_pkg::t_sum_num              o_sum_num,
    output rarc_pkg::t_sum_den              o_sum_den,
    output logic                            o_sum_whole,
    output logic                            o_a_less_b,
    output logic                            o_a_equal_b,
    output logic                            o_a_nonzero
);
    import rarc_pkg::*;

    t_cmd cmd;
    t_sts sts;

    rarc_ctrl #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    rarc_dp #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_dp (
        .i_clk       (i_clk),
        .i_a_num     (i_a_num),
        .i_a_den     (i_a_den),
        .i_b_num     (i_b_num),
        .i_b_den     (i_b_den),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_sum_num   (o_sum_num),
        .o_sum_den   (o_sum_den),
        .o_sum_whole (o_sum_whole),
        .o_a_less_b  (o_a_less_b),
        .o_a_equal_b (o_a_equal_b),
        .o_a_nonzero (o_a_nonzero)
    );

endmodule

@@ hw/rtl/rarc_ctrl.sv @@
// Controller for the rational add/reduce/compare core.
// Sequences multiply, add, gcd and divide phases; owns the handshakes.
// Depends on rarc_pkg.
module rarc_ctrl #(
    parameter int OPERAND_WIDTH = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_valid,
    output logic         o_in_stall,
    output logic         o_out_valid,
    input  logic         i_out_stall,
    input  rarc_pkg::t_sts i_sts,
    output rarc_pkg::t_cmd o_cmd
);
    import rarc_pkg::*;

    localparam int P   = 2 * OPERAND_WIDTH;
    localparam int CW  = $clog2(P);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_ADD  = 3'd2;
    localparam logic [2:0] S_GCD  = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;

    logic [2:0]    r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_ovalid, n_ovalid;
    logic          out_free;

    assign out_free    = !r_ovalid || !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_ovalid;

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_ovalid = r_ovalid && i_out_stall;
        o_cmd    = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_ADD;
            end
            S_ADD: begin
                o_cmd.add = 1'b1;
                n_state   = S_GCD;
            end
            S_GCD: begin
                if (i_sts.gcd_done) begin
                    o_cmd.div_init = 1'b1;
                    n_cnt          = '0;
                    n_state        = S_DIV;
                end else begin
                    o_cmd.gcd_step = 1'b1;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == CW'(P - 1)) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_ovalid       = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_ovalid <= n_ovalid;
        end
    end

endmodule

@@ hw/rtl/rarc_dp.sv @@
// Datapath for the rational add/reduce/compare core.
// Cross products, binary gcd and two restoring dividers, plus result registers.
// Depends on rarc_pkg.
module rarc_dp #(
    parameter int OPERAND_WIDTH = 16
) (
    input  logic                            i_clk,
    input  logic signed [OPERAND_WIDTH-1:0] i_a_num,
    input  logic        [OPERAND_WIDTH-2:0] i_a_den,
    input  logic signed [OPERAND_WIDTH-1:0] i_b_num,
    input  logic        [OPERAND_WIDTH-2:0] i_b_den,
    input  rarc_pkg::t_cmd                  i_cmd,
    output rarc_pkg::t_sts                  o_sts,
    output rarc_pkg::t_sum_num              o_sum_num,
    output rarc_pkg::t_sum_den              o_sum_den,
    output logic                            o_sum_whole,
    output logic                            o_a_less_b,
    output logic                            o_a_equal_b,
    output logic                            o_a_nonzero
);
    import rarc_pkg::*;

    localparam int W  = OPERAND_WIDTH;
    localparam int P  = 2 * W;
    localparam int KW = $clog2(P) + 1;

    logic signed [W-1:0] r_an, r_bn;
    logic        [W-2:0] r_ad, r_bd;
    logic signed [P-1:0] r_left, r_right;
    logic        [P-1:0] r_den;
    logic        [P-1:0] r_mag;
    logic                r_neg, r_less, r_equal, r_anz;
    logic        [P-1:0] r_x, r_y, r_g;
    logic       [KW-1:0] r_k;
    logic        [P-1:0] r_qn, r_qd;
    logic          [P:0] r_rn, r_rd;

    t_sum_num r_sum_num;
    t_sum_den r_sum_den;
    logic     r_whole, r_o_less, r_o_equal, r_o_anz;

    logic signed [P-1:0] total;
    logic        [P-1:0] diff_xy, diff_yx;
    logic          [P:0] sh_n, sh_d, g_ext;
    logic signed   [P:0] snum;

    assign total   = r_left + r_right;
    assign diff_xy = r_x - r_y;
    assign diff_yx = r_y - r_x;
    assign sh_n    = {r_rn[P-1:0], r_qn[P-1]};
    assign sh_d    = {r_rd[P-1:0], r_qd[P-1]};
    assign g_ext   = {1'b0, r_g};
    assign snum    = r_neg ? -$signed({1'b0, r_qn}) : $signed({1'b0, r_qn});

    assign o_sts.gcd_done = (r_x == '0);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_an <= i_a_num;
            r_bn <= i_b_num;
            r_ad <= (i_a_den == '0) ? (W-1)'(1) : i_a_den;
            r_bd <= (i_b_den == '0) ? (W-1)'(1) : i_b_den;
        end
        if (i_cmd.mul) begin
            r_left  <= P'(r_an * $signed({1'b0, r_bd}));
            r_right <= P'(r_bn * $signed({1'b0, r_ad}));
            r_den   <= P'(r_ad * r_bd);
            r_anz   <= (r_an != '0);
        end
        if (i_cmd.add) begin
            r_neg   <= total[P-1];
            r_mag   <= total[P-1] ? P'(-total) : P'(total);
            r_less  <= (r_left < r_right);
            r_equal <= (r_left == r_right);
            r_x     <= total[P-1] ? P'(-total) : P'(total);
            r_y     <= r_den;
            r_k     <= '0;
        end
        if (i_cmd.gcd_step) begin
            priority if (!r_x[0] && !r_y[0]) begin
                r_x <= r_x >> 1;
                r_y <= r_y >> 1;
                r_k <= r_k + 1'b1;
            end else if (!r_x[0]) begin
                r_x <= r_x >> 1;
            end else if (!r_y[0]) begin
                r_y <= r_y >> 1;
            end else if (r_x >= r_y) begin
                r_x <= diff_xy >> 1;
            end else begin
                r_y <= diff_yx >> 1;
            end
        end
        if (i_cmd.div_init) begin
            r_g  <= r_y << r_k;
            r_qn <= r_mag;
            r_qd <= r_den;
            r_rn <= '0;
            r_rd <= '0;
        end
        if (i_cmd.div_step) begin
            if (sh_n >= g_ext) begin
                r_rn <= sh_n - g_ext;
                r_qn <= {r_qn[P-2:0], 1'b1};
            end else begin
                r_rn <= sh_n;
                r_qn <= {r_qn[P-2:0], 1'b0};
            end
            if (sh_d >= g_ext) begin
                r_rd <= sh_d - g_ext;
                r_qd <= {r_qd[P-2:0], 1'b1};
            end else begin
                r_rd <= sh_d;
                r_qd <= {r_qd[P-2:0], 1'b0};
            end
        end
        if (i_cmd.out_load) begin
            r_sum_num <= SUM_NUM_W'(snum);
            r_sum_den <= SUM_DEN_W'(r_qd);
            r_whole   <= (r_qd == P'(1));
            r_o_less  <= r_less;
            r_o_equal <= r_equal;
            r_o_anz   <= r_anz;
        end
    end

    assign o_sum_num   = r_sum_num;
    assign o_sum_den   = r_sum_den;
    assign o_sum_whole = r_whole;
    assign o_a_less_b  = r_o_less;
    assign o_a_equal_b = r_o_equal;
    assign o_a_nonzero = r_o_anz;

endmodule

@@ hw/rtl/rarc_check.sv @@
// Port-level checker for the rational add/reduce/compare core, bound to the top level.
// Depends on rarc_pkg.
module rarc_check (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_stall,
    input logic                 o_out_valid,
    input logic                 i_out_stall,
    input rarc_pkg::t_sum_den   o_sum_den,
    input logic                 o_sum_whole,
    input logic                 o_a_less_b,
    input logic                 o_a_equal_b
);
    import rarc_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result word dropped while stalled");

    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input not stalled after taking a word");

    a_whole_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_sum_whole |-> o_sum_den == SUM_DEN_W'(1))
        else $error("whole flag with denominator not one");

    a_cmp_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_a_equal_b |-> !o_a_less_b)
        else $error("equal and less both set");

endmodule

bind rational_add_reduce_compare_core rarc_check u_rarc_check (.*);
